// ===== hw/rtl/set_assoc_cache_lru_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag lookup
// Clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH

// plain property check
`define SACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication check
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the cache tag lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

  localparam int TAG_W   = 30;
  localparam int STAMP_W = 32;
  localparam int ADDR_W  = 32;
  localparam int CFG_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int WORD_BYTES_LOG2 = 2;

  // one stored way of a set
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [CIDX_W-1:0] {
    CFG_BLOCK_SHIFT = 2'd0,
    CFG_SETS_LOG2   = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_index_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lru_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Tag store and LRU replacement of a set-associative cache
// ----------------------------------------------------------------------------
// After reset the block sweeps its tag RAM to clear every valid bit;
// in_ready stays low until the sweep ends. Each item is accepted in the
// idle state and then walks the ways of its set one at a time through the
// single read port of the tag RAM and one shared tag compare and age
// subtract, with a read state and a check state per way visited; a hit
// ends the walk at its way, a miss after all ways in use. Then a write-back
// state writes the tag and stamp, stalling while a held result is not taken.
// One result item comes out per input item and is held in an output register
// until taken, while the next input item may already be accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lru_lookup_assert.svh"

module set_assoc_cache_lru_lookup
  import sacl_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [STAMP_W-1:0] stamp,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   hit,
  output logic [1:0]             way
);

  localparam int ENTRIES  = SETS * WAYS;
  localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int MAX_SLOG = $clog2(SETS + 1) - 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] block_shift;
  logic [CFG_W-1:0] sets_log2;
  logic [CFG_W-1:0] ways_in_use;

  logic [AW-1:0]      clr_addr;
  logic [TAG_W-1:0]   tag_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [AW-1:0]      base_r;
  logic [CNT_W-1:0]   nways_r;
  logic [WAY_W-1:0]   cnt;
  logic               inv_found;
  logic [WAY_W-1:0]   inv_way;
  logic [STAMP_W-1:0] best_age;
  logic [WAY_W-1:0]   best_way;
  logic               hit_r;
  logic [WAY_W-1:0]   sel_way;

  // geometry decode of the incoming address
  logic [CFG_W-1:0]  eff_slog;
  logic [CNT_W-1:0]  eff_ways;
  logic [3:0]        blk_shamt;
  logic [ADDR_W-1:0] block_num;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_idx;

  assign eff_slog  = (32'(sets_log2) > MAX_SLOG) ? CFG_W'(MAX_SLOG) : sets_log2;
  assign eff_ways  = (ways_in_use == '0) ? CNT_W'(1) :
                     (32'(ways_in_use) > WAYS) ? CNT_W'(WAYS) : CNT_W'(ways_in_use);
  assign blk_shamt = 4'(WORD_BYTES_LOG2) + 4'(block_shift);
  assign block_num = address >> blk_shamt;
  assign set_mask  = ~({SET_W{1'b1}} << eff_slog);
  assign set_idx   = SET_W'(block_num) & set_mask;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        rd;

  assign ram_raddr = base_r + AW'(cnt);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_r + AW'(sel_way);
    ram_wdata = '{valid: 1'b1, tag: tag_r, stamp: stamp_r};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_WRITE && (!out_valid || out_ready)) begin
      ram_we = 1'b1;
    end
  end

  sacl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // shared compare and age unit, one way per check cycle
  logic               way_hit;
  logic [STAMP_W-1:0] age;
  logic               inv_found_next;
  logic [WAY_W-1:0]   inv_way_next;
  logic [STAMP_W-1:0] best_age_next;
  logic [WAY_W-1:0]   best_way_next;
  logic [WAY_W-1:0]   victim;
  logic               last_way;

  always_comb begin
    way_hit        = rd.valid && (rd.tag == tag_r);
    age            = stamp_r - rd.stamp;
    inv_found_next = inv_found;
    inv_way_next   = inv_way;
    best_age_next  = best_age;
    best_way_next  = best_way;
    if (!rd.valid && !inv_found) begin
      inv_found_next = 1'b1;
      inv_way_next   = cnt;
    end
    if (rd.valid && age > best_age) begin
      best_age_next = age;
      best_way_next = cnt;
    end
    victim   = inv_found_next ? inv_way_next : best_way_next;
    last_way = (CNT_W'(cnt) + CNT_W'(1)) == nways_r;
  end

  assign in_ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= CFG_W'(0);
      sets_log2   <= CFG_W'(6);
      ways_in_use <= CFG_W'(4);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLOCK_SHIFT: block_shift <= cfg_data;
        CFG_SETS_LOG2:   sets_log2   <= cfg_data;
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // write-back sets out_valid itself when it hands over a new item
      if (out_valid && out_ready && state != S_WRITE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            tag_r     <= TAG_W'(block_num >> eff_slog);
            stamp_r   <= stamp;
            base_r    <= AW'(set_idx) * AW'(WAYS);
            nways_r   <= eff_ways;
            cnt       <= '0;
            inv_found <= 1'b0;
            inv_way   <= '0;
            best_age  <= '0;
            best_way  <= '0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          inv_found <= inv_found_next;
          inv_way   <= inv_way_next;
          best_age  <= best_age_next;
          best_way  <= best_way_next;
          if (way_hit) begin
            hit_r   <= 1'b1;
            sel_way <= cnt;
            state   <= S_WRITE;
          end else if (last_way) begin
            hit_r   <= 1'b0;
            sel_way <= victim;
            state   <= S_WRITE;
          end else begin
            cnt   <= cnt + WAY_W'(1);
            state <= S_READ;
          end
        end
        S_WRITE: begin
          // hit refreshes the stamp, miss fills the victim: same word either way
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= hit_r;
            way       <= 2'(sel_way);
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `SACL_ASSERT_IMP(a_no_accept_in_clear, state == S_CLEAR, !in_ready,
    "item accepted during clearing pass")
  `SACL_ASSERT_IMP(a_scan_in_range, state == S_CHECK, CNT_W'(cnt) < nways_r,
    "way scan ran past ways in use")
  `SACL_ASSERT(a_result_from_write, $rose(out_valid) |-> $past(state) == S_WRITE,
    "result raised outside write-back")
  `SACL_ASSERT(a_write_ends_item, (state == S_WRITE) && ram_we |=> state == S_IDLE,
    "write-back did not end the item")

endmodule

`default_nettype wire
